@@ hdl/ncp_pkg.sv @@
// shared types and constants for the nearest color palette unit
package ncp_pkg;

    localparam int CH_W       = 8;
    localparam int DIST_W     = 10;
    localparam int LUM_W      = 15;
    localparam int GRAY_W     = 5;
    localparam int GRAY_SUM_W = 8;
    localparam int GRAY_MAX   = 31;
    localparam int GRAY_DIV   = 25500;
    localparam int LUM_R_COEF = 30;
    localparam int LUM_G_COEF = 59;
    localparam int LUM_B_COEF = 11;
    localparam int RECIP_SHIFT = 30;
    localparam logic [CH_W-1:0] CH_FULL = 8'hFF;
    localparam logic [CH_W-1:0] CH_ZERO = 8'h00;
    localparam logic [GRAY_W-1:0] GRAY_BLACK = 5'd0;
    localparam logic [GRAY_W-1:0] GRAY_WHITE = 5'd1;

    typedef struct packed {
        logic [CH_W-1:0] red_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] blue_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0]        palette_index;
        logic              exact_match;
        logic              entry_added;
        logic [GRAY_W-1:0] gray_pattern;
        logic              gray_valid;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic start;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_busy;
        logic gray_busy;
    } ctrl_status_t;

    function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

@@ hdl/ncp_gray_div.sv @@
// luminance and reciprocal multiply for the gray pattern level
module ncp_gray_div
    import ncp_pkg::*;
#(
    parameter int GRAY_LEVELS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [CH_W-1:0]                       red,
    input  logic [CH_W-1:0]                       green,
    input  logic [CH_W-1:0]                       blue,
    output logic                                  busy,
    output logic [$clog2(GRAY_LEVELS+1)-1:0]      level
);

    localparam int     Q_W     = $clog2(GRAY_LEVELS + 1);
    // rounded-up reciprocal, exact floor for every luminance up to the divisor
    localparam longint RECIP_L = ((longint'(GRAY_LEVELS) << RECIP_SHIFT)
                                 + longint'(GRAY_DIV) - 1) / longint'(GRAY_DIV);
    localparam int     RECIP_W = $clog2(RECIP_L + 1);
    localparam int     PROD_W  = LUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

    logic              load_reg, load_next;
    logic [LUM_W-1:0]  lum_reg, lum_next;
    logic [Q_W-1:0]    q_reg, q_next;
    logic [PROD_W-1:0] prod;

    assign prod = PROD_W'(lum_reg) * PROD_W'(RECIP);

    always_comb
    begin
        load_next = start;
        lum_next  = lum_reg;
        q_next    = q_reg;
        if (start)
        begin
            lum_next  = LUM_W'(LUM_R_COEF) * LUM_W'(red)
                      + LUM_W'(LUM_G_COEF) * LUM_W'(green)
                      + LUM_W'(LUM_B_COEF) * LUM_W'(blue);
        end
        else if (load_reg)
        begin
            q_next = prod[RECIP_SHIFT +: Q_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg <= 1'b0;
        end
        else
        begin
            load_reg <= load_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lum_reg <= lum_next;
        q_reg   <= q_next;
    end

    assign busy  = load_reg;
    assign level = q_reg;

endmodule

@@ hdl/ncp_datapath.sv @@
// palette memory, l1 scan, append logic, config register and result register
module ncp_datapath
    import ncp_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256,
    parameter int GRAY_LEVELS   = 16,
    parameter int GRAY_BASE     = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  ctrl_cmd_t    cmd,
    output ctrl_status_t status,
    input  in_item_t     in_data,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_data,
    output out_item_t    out_data
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int Q_W   = $clog2(GRAY_LEVELS + 1);
    localparam logic [IDX_W-1:0] LAST_FREE = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [IDX_W-1:0] USED_INIT = IDX_W'(2);

    logic [3*CH_W-1:0] mem [TABLE_ENTRIES];
    logic [3*CH_W-1:0] mem_q_reg;

    in_item_t          color_reg;
    logic              mode_reg;
    logic [IDX_W-1:0]  used_reg, used_next;
    logic              scan_active_reg, scan_active_next;
    logic [IDX_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic              rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic [DIST_W-1:0] best_dist_reg, best_dist_next;
    logic              exact_reg, exact_next;
    out_item_t         result_reg;

    logic              issue;
    logic              hit;
    logic              append;
    logic [3*CH_W-1:0] entry;
    logic [DIST_W-1:0] scan_dist;
    logic              gray_busy;
    logic [Q_W-1:0]    gray_level;
    logic [GRAY_SUM_W-1:0] gray_sum;
    logic [GRAY_W-1:0] gray_code;
    logic [IDX_W-1:0]  final_idx;
    logic [IDX_W+7:0]  idx_ext;

    ncp_gray_div #(
        .GRAY_LEVELS(GRAY_LEVELS)
    ) u_gray_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.start),
        .red   (color_reg.red_in),
        .green (color_reg.green_in),
        .blue  (color_reg.blue_in),
        .busy  (gray_busy),
        .level (gray_level)
    );

    // entries 0 and 1 are fixed white and black and never rewritten
    always_comb
    begin
        if (rd_idx_reg == '0)
            entry = {CH_FULL, CH_FULL, CH_FULL};
        else if (rd_idx_reg == IDX_W'(1))
            entry = {CH_ZERO, CH_ZERO, CH_ZERO};
        else
            entry = mem_q_reg;
    end

    assign scan_dist = DIST_W'(abs_diff(entry[3*CH_W-1:2*CH_W], color_reg.red_in))
                     + DIST_W'(abs_diff(entry[2*CH_W-1:CH_W], color_reg.green_in))
                     + DIST_W'(abs_diff(entry[CH_W-1:0], color_reg.blue_in));

    assign hit   = scan_active_reg && rd_valid_reg && (scan_dist == '0);
    assign issue = scan_active_reg && (rd_ptr_reg < used_reg) && !hit;

    always_comb
    begin
        scan_active_next = scan_active_reg;
        rd_ptr_next      = rd_ptr_reg;
        rd_valid_next    = issue;
        best_idx_next    = best_idx_reg;
        best_dist_next   = best_dist_reg;
        exact_next       = exact_reg;
        if (cmd.start)
        begin
            scan_active_next = 1'b1;
            rd_ptr_next      = '0;
            rd_valid_next    = 1'b0;
            exact_next       = 1'b0;
            best_idx_next    = '0;
        end
        else if (scan_active_reg)
        begin
            if (issue)
                rd_ptr_next = rd_ptr_reg + 1'b1;
            if (hit)
            begin
                scan_active_next = 1'b0;
                exact_next       = 1'b1;
                best_idx_next    = rd_idx_reg;
            end
            else if (rd_valid_reg)
            begin
                if (rd_idx_reg == '0 || scan_dist < best_dist_reg)
                begin
                    best_idx_next  = rd_idx_reg;
                    best_dist_next = scan_dist;
                end
            end
            else if (rd_ptr_reg >= used_reg)
                scan_active_next = 1'b0;
        end
    end

    assign append    = !exact_reg && (used_reg < LAST_FREE);
    assign final_idx = append ? used_reg : best_idx_reg;
    assign idx_ext   = {8'd0, final_idx};
    assign used_next = (cmd.finish && append) ? used_reg + 1'b1 : used_reg;

    // gray code with black and white named apart, saturating on large settings
    always_comb
    begin
        gray_sum = GRAY_SUM_W'(GRAY_BASE) + GRAY_SUM_W'(gray_level);
        if (color_reg == {CH_ZERO, CH_ZERO, CH_ZERO})
            gray_code = GRAY_BLACK;
        else if (color_reg == {CH_FULL, CH_FULL, CH_FULL})
            gray_code = GRAY_WHITE;
        else if (gray_sum > GRAY_SUM_W'(GRAY_MAX))
            gray_code = GRAY_W'(GRAY_MAX);
        else
            gray_code = gray_sum[GRAY_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= 1'b1;
            used_reg        <= USED_INIT;
            scan_active_reg <= 1'b0;
            rd_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                mode_reg <= cfg_data;
            used_reg        <= used_next;
            scan_active_reg <= scan_active_next;
            rd_valid_reg    <= rd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            color_reg <= in_data;
        rd_ptr_reg    <= rd_ptr_next;
        best_idx_reg  <= best_idx_next;
        best_dist_reg <= best_dist_next;
        exact_reg     <= exact_next;
        if (issue)
            rd_idx_reg <= rd_ptr_reg;
        if (cmd.finish)
        begin
            result_reg.palette_index <= idx_ext[7:0];
            result_reg.exact_match   <= exact_reg;
            result_reg.entry_added   <= append;
            result_reg.gray_pattern  <= mode_reg ? GRAY_BLACK : gray_code;
            result_reg.gray_valid    <= !mode_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
            mem_q_reg <= mem[rd_ptr_reg];
        if (cmd.finish && append)
            mem[used_reg] <= color_reg;
    end

    assign cfg_ready = 1'b1;
    assign status    = '{scan_busy: scan_active_reg, gray_busy: gray_busy};
    assign out_data  = result_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg >= USED_INIT) && (used_reg <= LAST_FREE))
        else $error("palette fill count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        scan_active_reg |-> (rd_ptr_reg <= used_reg))
        else $error("scan read pointer passed the fill count");

    assert property (@(posedge clk) disable iff (!rst_n)
        hit |=> !scan_active_reg && exact_reg)
        else $error("exact match did not stop the scan");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> used_reg == $past(used_reg) + IDX_W'($past(append)))
        else $error("fill count did not follow the append");

endmodule

@@ hdl/ncp_ctrl.sv @@
// controller state machine sequencing load, search and result transfer
module ncp_ctrl
    import ncp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_BUSY  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       done;

    assign done = !status.scan_busy && !status.gray_busy;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                cmd.start  = 1'b1;
                state_next = ST_BUSY;
            end
            ST_BUSY:
            begin
                if (done && (!out_valid_reg || out_ready))
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !status.scan_busy && !status.gray_busy)
        else $error("result taken while search still busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_START) |=> status.scan_busy && status.gray_busy)
        else $error("search units did not start");

endmodule

@@ hdl/nearest_color_palette_unit.sv @@
// top level of the nearest color palette unit
// result: registered once both the palette scan and the gray unit are done, where the palette
// scan stops at an exact match and otherwise reads all entries_used entries, with one
// palette memory read a cycle
// throughput: one item at a time, a new input taken only after the result is registered,
// and later while an earlier result waits for its transfer
// reset: color_mode 1, palette holds white at 0 and black at 1, entries_used 2,
// no clearing pass since entries 0 and 1 are fixed in logic
module nearest_color_palette_unit
    import ncp_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256,
    parameter int GRAY_LEVELS   = 16,
    parameter int GRAY_BASE     = 2
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_data
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    ncp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    ncp_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .GRAY_LEVELS   (GRAY_LEVELS),
        .GRAY_BASE     (GRAY_BASE)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .out_data  (out_data)
    );

endmodule
